// ===== design/xorshift_pattern_memory_checker_macros.svh =====
// assertion macros for the xorshift pattern memory checker
// used by the checker module; expects clk_i and rst_ni in scope
`ifndef XORSHIFT_PATTERN_MEMORY_CHECKER_MACROS_SVH
`define XORSHIFT_PATTERN_MEMORY_CHECKER_MACROS_SVH

// property checked on every rising edge outside reset
`define XPMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define XPMC_ASSERT_NEVER(lbl, cond, msg) \
  `XPMC_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/xpmc_pkg.sv =====
// shared types, constants and the xorshift32 step for the pattern checker
// no dependencies
package xpmc_pkg;

  localparam int GROUP_WORDS = 8;

  localparam int DATA_W  = 32;
  localparam int GROUP_W = 21;
  localparam int POS_W   = 23;
  localparam int ERR_W   = 24;
  localparam int TOTAL_W = 24;

  localparam logic [GROUP_W-1:0] GROUP_COUNT_MAX   = 21'd1048576;
  localparam logic [GROUP_W-1:0] GROUP_COUNT_RESET = 21'd524288;
  localparam logic [DATA_W-1:0]  SEED_RESET        = 32'd1;
  localparam logic [ERR_W-1:0]   ERR_MAX           = 24'hFFFFFF;

  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 5;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_PHASE = 1'b1;

  // register index (byte address bit 2)
  localparam logic REG_SEED   = 1'b0;
  localparam logic REG_GROUPS = 1'b1;

  localparam int PADDR_W = 3;

  typedef struct packed {
    logic [DATA_W-1:0]  seed;
    logic [GROUP_W-1:0] group_count;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_word;
    logic [POS_W-1:0]  word_index;
    logic              mismatch;
    logic [ERR_W-1:0]  error_total;
    logic              pass_end;
    logic              status;
  } result_t;

  function automatic logic [DATA_W-1:0] advance(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    a = x ^ (x << SHIFT_A);
    b = a ^ (a >> SHIFT_B);
    return b ^ (b << SHIFT_C);
  endfunction

endpackage

// ===== design/xpmc_cfg.sv =====
// apb configuration registers: seed and group count
// depends on xpmc_pkg
module xpmc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [xpmc_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output xpmc_pkg::cfg_t                  cfg_o
);

  logic [xpmc_pkg::DATA_W-1:0]  seed_q;
  logic [xpmc_pkg::GROUP_W-1:0] groups_q;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= xpmc_pkg::SEED_RESET;
      groups_q <= xpmc_pkg::GROUP_COUNT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        xpmc_pkg::REG_SEED:   seed_q   <= pwdata;
        xpmc_pkg::REG_GROUPS: groups_q <= pwdata[xpmc_pkg::GROUP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      xpmc_pkg::REG_SEED:   prdata = seed_q;
      xpmc_pkg::REG_GROUPS: prdata = {{(32-xpmc_pkg::GROUP_W){1'b0}}, groups_q};
      default:              prdata = '0;
    endcase
  end

  assign cfg_o.seed        = seed_q;
  assign cfg_o.group_count = groups_q;

endmodule

// ===== design/xpmc_engine.sv =====
// pass state (phase, position, generator, error count) and per-word result logic
// depends on xpmc_pkg
module xpmc_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic                          op_i,
  input  logic [xpmc_pkg::DATA_W-1:0]   read_data_i,
  input  xpmc_pkg::cfg_t                cfg_i,
  output xpmc_pkg::result_t             result_o
);

  logic                           verify_q, verify_d;
  logic [xpmc_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [xpmc_pkg::DATA_W-1:0]    gen_q, gen_d;
  logic [xpmc_pkg::ERR_W-1:0]     err_q, err_d;

  logic [xpmc_pkg::GROUP_W-1:0]   groups_eff;
  logic [xpmc_pkg::TOTAL_W-1:0]   total;
  logic [xpmc_pkg::TOTAL_W-1:0]   pos_inc;
  logic                           phase_ok;
  logic                           first_word;
  logic                           last_word;
  logic [xpmc_pkg::DATA_W-1:0]    gen_next;
  logic [xpmc_pkg::ERR_W-1:0]     err_base;
  logic                           miss;

  // clamp group count to 1..max
  always_comb begin
    if (cfg_i.group_count == '0) begin
      groups_eff = xpmc_pkg::GROUP_W'(1);
    end else if (cfg_i.group_count > xpmc_pkg::GROUP_COUNT_MAX) begin
      groups_eff = xpmc_pkg::GROUP_COUNT_MAX;
    end else begin
      groups_eff = cfg_i.group_count;
    end
  end

  assign total      = xpmc_pkg::TOTAL_W'(groups_eff) *
                      xpmc_pkg::TOTAL_W'(xpmc_pkg::GROUP_WORDS);
  assign pos_inc    = {1'b0, pos_q} + xpmc_pkg::TOTAL_W'(1);
  assign phase_ok   = (op_i == verify_q);
  assign first_word = (pos_q == '0);
  assign last_word  = (pos_inc >= total);
  assign gen_next   = xpmc_pkg::advance(first_word ? cfg_i.seed : gen_q);
  assign err_base   = (first_word && verify_q) ? '0 : err_q;
  assign miss       = verify_q && (read_data_i != gen_next);

  always_comb begin
    verify_d = verify_q;
    pos_d    = pos_q;
    gen_d    = gen_q;
    err_d    = err_q;
    result_o.data_word   = '0;
    result_o.word_index  = pos_q;
    result_o.mismatch    = 1'b0;
    result_o.error_total = err_q;
    result_o.pass_end    = 1'b0;
    result_o.status      = xpmc_pkg::STATUS_BAD_PHASE;
    if (phase_ok) begin
      gen_d = gen_next;
      err_d = err_base;
      if (miss && (err_base != xpmc_pkg::ERR_MAX)) begin
        err_d = err_base + xpmc_pkg::ERR_W'(1);
      end
      if (last_word) begin
        pos_d    = '0;
        verify_d = !verify_q;
      end else begin
        pos_d = pos_inc[xpmc_pkg::POS_W-1:0];
      end
      result_o.data_word   = gen_next;
      result_o.mismatch    = miss;
      result_o.error_total = err_d;
      result_o.pass_end    = last_word;
      result_o.status      = xpmc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verify_q <= 1'b0;
      pos_q    <= '0;
      err_q    <= '0;
    end else if (fire_i) begin
      verify_q <= verify_d;
      pos_q    <= pos_d;
      err_q    <= err_d;
    end
  end

  // loaded from seed before first use in every pass
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      gen_q <= gen_d;
    end
  end

endmodule

// ===== design/xorshift_pattern_memory_checker.sv =====
// top level of the xorshift32 memory test pattern engine
// depends on xpmc_pkg, xpmc_cfg, xpmc_engine
//
//   channel   direction  handshake               word
//   in        sink       in_valid_i / in_stall_o  op, read_data
//   out       source     out_valid_o / out_stall_i data_word .. status
//   cfg       apb slave  psel/penable/pwrite       seed @0x0, group_count @0x4
//
// one word per cycle sustained while the output does not stall; a taken word sits
// in the input register, moves through the generator/compare logic into the result
// register and shows on the output from there. the pass state updates as the word
// moves into the result register.
// reset clears phase, position, error count and both valid flags; the generator
// reloads from seed on the first word of every pass.
// a stall on the output holds the result register, and the input register
// stalls the input only when it is full and cannot move forward.
module xorshift_pattern_memory_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               in_op_i,
  input  logic [xpmc_pkg::DATA_W-1:0]        in_read_data_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [xpmc_pkg::DATA_W-1:0]        out_data_word_o,
  output logic [xpmc_pkg::POS_W-1:0]         out_word_index_o,
  output logic                               out_mismatch_o,
  output logic [xpmc_pkg::ERR_W-1:0]         out_error_total_o,
  output logic                               out_pass_end_o,
  output logic                               out_status_o,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [xpmc_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  xpmc_pkg::cfg_t    cfg;
  xpmc_pkg::result_t result;
  xpmc_pkg::result_t res_q;

  // input register
  logic                        in_valid_q;
  logic                        in_op_q;
  logic [xpmc_pkg::DATA_W-1:0] in_rd_q;
  logic                        out_valid_q;

  logic out_ready;   // result register can take a word this cycle
  logic advance_w;   // input register word moves into the result register
  logic in_take;     // new input word accepted

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance_w  = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  xpmc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  xpmc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance_w),
    .op_i        (in_op_q),
    .read_data_i (in_rd_q),
    .cfg_i       (cfg),
    .result_o    (result)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance_w) begin
        in_valid_q <= 1'b0;
      end
      if (advance_w) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q <= in_op_i;
      in_rd_q <= in_read_data_i;
    end
    if (advance_w) begin
      res_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_word_o   = res_q.data_word;
  assign out_word_index_o  = res_q.word_index;
  assign out_mismatch_o    = res_q.mismatch;
  assign out_error_total_o = res_q.error_total;
  assign out_pass_end_o    = res_q.pass_end;
  assign out_status_o      = res_q.status;

endmodule

// ===== design/xpmc_checker.sv =====
// port-level assertions for the pattern engine, bound to the top level
// depends on xorshift_pattern_memory_checker_macros.svh and xpmc_pkg
`include "xorshift_pattern_memory_checker_macros.svh"

module xpmc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [xpmc_pkg::DATA_W-1:0]  out_data_word_o,
  input logic                         out_mismatch_o,
  input logic [xpmc_pkg::ERR_W-1:0]   out_error_total_o
);

  // a stalled result word holds
  `XPMC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_word_o), "result word changed under stall")

  // input only backs up when the output is blocked
  `XPMC_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled while output free")

  // an accepted word reaches the output via the input and result registers when the output does not stall
  `XPMC_ASSERT(a_latency, (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o, "accepted word did not reach output")

  // a mismatch is always counted
  `XPMC_ASSERT_NEVER(a_miss_count, out_valid_o && out_mismatch_o && (out_error_total_o == '0), "mismatch with zero error total")

endmodule

bind xorshift_pattern_memory_checker xpmc_checker u_xpmc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .out_data_word_o   (out_data_word_o),
  .out_mismatch_o    (out_mismatch_o),
  .out_error_total_o (out_error_total_o)
);
